/* rtl/dht11_pkg.sv */
`default_nettype none
package dht11_pkg;

  localparam int unsigned BYTES_PER_FRAME = 5;
  localparam int unsigned BITS_PER_BYTE   = 8;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned DELAY_W = 8;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // register map, byte address = 4 * index
  localparam logic [1:0] REG_REQUEST_LOW      = 2'd0;
  localparam logic [1:0] REG_SAMPLE_DELAY     = 2'd1;
  localparam logic [1:0] REG_RESPONSE_TIMEOUT = 2'd2;

  localparam logic [TICK_W-1:0]  REQUEST_LOW_RESET      = 16'd20000;
  localparam logic [DELAY_W-1:0] SAMPLE_DELAY_RESET     = 8'd30;
  localparam logic [TICK_W-1:0]  RESPONSE_TIMEOUT_RESET = 16'd2000;

  localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(BITS_PER_BYTE - 1);
  localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(BYTES_PER_FRAME - 1);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_REQUEST   = 3'd1,
    PH_WAIT_RESP = 3'd2,
    PH_RESP_LOW  = 3'd3,
    PH_RESP_HIGH = 3'd4,
    PH_WAIT_RISE = 3'd5,
    PH_SAMPLE    = 3'd6,
    PH_WAIT_FALL = 3'd7
  } phase_t;

  typedef struct packed {
    logic start_req;
    logic pin_level;
  } item_t;

  typedef struct packed {
    logic             drive_low;
    logic             byte_valid;
    logic [7:0]       byte_value;
    logic [CNT_W-1:0] byte_index;
    logic             last_byte;
    logic             timed_out;
    logic             busy_res;
  } result_t;

endpackage
`default_nettype wire

/* rtl/dht11_single_wire_receiver.sv */
`default_nettype none
// A result appears in the output register in the cycle after its transaction is taken.
// Throughput: one transaction per cycle; the next item is taken in the same cycle the held
//   result is taken, so the input stalls only while the output register is full and stalled.
// Reset (rst, synchronous, active high): phase idle, counters and shift register cleared,
//   configuration registers back to 20000 / 30 / 2000 ticks, no result held.
module dht11_single_wire_receiver
  import dht11_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // input channel: one transaction per microsecond tick
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire item_t             item,
  // result channel: one transaction per input transaction
  output logic                   result_valid,
  input  wire logic              result_stall,
  output result_t                result,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0]  request_low_ticks;
  logic [DELAY_W-1:0] sample_delay_ticks;
  logic [TICK_W-1:0]  response_timeout_ticks;
  logic               cfg_write;
  logic [1:0]         cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      request_low_ticks      <= REQUEST_LOW_RESET;
      sample_delay_ticks     <= SAMPLE_DELAY_RESET;
      response_timeout_ticks <= RESPONSE_TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REQUEST_LOW:      request_low_ticks      <= pwdata[TICK_W-1:0];
        REG_SAMPLE_DELAY:     sample_delay_ticks     <= pwdata[DELAY_W-1:0];
        REG_RESPONSE_TIMEOUT: response_timeout_ticks <= pwdata[TICK_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_REQUEST_LOW:      prdata = {{(DATA_W-TICK_W){1'b0}}, request_low_ticks};
      REG_SAMPLE_DELAY:     prdata = {{(DATA_W-DELAY_W){1'b0}}, sample_delay_ticks};
      REG_RESPONSE_TIMEOUT: prdata = {{(DATA_W-TICK_W){1'b0}}, response_timeout_ticks};
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: the output register frees itself the same cycle it is taken,
  // so input and output move together at one transaction per cycle unless the result side stalls.
  // ---------------------------------------------------------------------------
  logic take;

  assign item_stall = result_valid && result_stall;
  assign take       = item_valid && !item_stall;

  // ---------------------------------------------------------------------------
  // Receiver state
  // ---------------------------------------------------------------------------
  phase_t             phase, phase_next;
  logic [TICK_W-1:0]  tick_count, tick_count_next;
  logic [7:0]         shift_reg, shift_reg_next;
  logic [CNT_W-1:0]   bit_count, bit_count_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [TICK_W-1:0]  tick_inc;
  logic [7:0]         shifted;
  result_t            result_next;

  // tick counter saturates at all ones
  assign tick_inc = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign shifted  = {shift_reg[6:0], item.pin_level};

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    shift_reg_next  = shift_reg;
    bit_count_next  = bit_count;
    byte_count_next = byte_count;
    result_next     = '0;

    if (item.start_req) begin
      // start wins in every phase; the wire is ignored on this tick
      phase_next      = PH_REQUEST;
      tick_count_next = '0;
      shift_reg_next  = '0;
      bit_count_next  = '0;
      byte_count_next = '0;
    end else begin
      case (phase)
        PH_REQUEST: begin
          tick_count_next = tick_inc;
          if (tick_inc >= request_low_ticks) begin
            phase_next      = PH_WAIT_RESP;
            tick_count_next = '0;
          end
        end
        PH_WAIT_RESP: begin
          if (!item.pin_level) begin
            phase_next      = PH_RESP_LOW;
            tick_count_next = '0;
          end else if (tick_count >= response_timeout_ticks) begin
            result_next.timed_out = 1'b1;
            phase_next            = PH_IDLE;
            tick_count_next       = '0;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        PH_RESP_LOW: begin
          if (item.pin_level) phase_next = PH_RESP_HIGH;
        end
        PH_RESP_HIGH: begin
          if (!item.pin_level) phase_next = PH_WAIT_RISE;
        end
        PH_WAIT_RISE: begin
          if (item.pin_level) begin
            phase_next      = PH_SAMPLE;
            tick_count_next = '0;
          end
        end
        PH_SAMPLE: begin
          tick_count_next = tick_inc;
          if (tick_inc >= {{(TICK_W-DELAY_W){1'b0}}, sample_delay_ticks}) begin
            tick_count_next = '0;
            shift_reg_next  = shifted;
            phase_next      = item.pin_level ? PH_WAIT_FALL : PH_WAIT_RISE;
            if (bit_count >= LAST_BIT) begin
              // byte complete
              result_next.byte_valid = 1'b1;
              result_next.byte_value = shifted;
              result_next.byte_index = byte_count;
              result_next.last_byte  = (byte_count >= LAST_BYTE);
              shift_reg_next         = '0;
              bit_count_next         = '0;
              byte_count_next        = byte_count + 1'b1;
              if (byte_count >= LAST_BYTE) begin
                phase_next      = PH_IDLE;
                byte_count_next = '0;
              end
            end else begin
              bit_count_next = bit_count + 1'b1;
            end
          end
        end
        PH_WAIT_FALL: begin
          if (!item.pin_level) phase_next = PH_WAIT_RISE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    result_next.drive_low = (phase_next == PH_REQUEST);
    result_next.busy_res  = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      shift_reg  <= '0;
      bit_count  <= '0;
      byte_count <= '0;
    end else if (take) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      shift_reg  <= shift_reg_next;
      bit_count  <= bit_count_next;
      byte_count <= byte_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_start_drives: assert property (@(posedge clk) disable iff (rst)
    take && item.start_req |=> result_valid && result.drive_low && result.busy_res)
    else $error("start transaction did not drive the wire low");

  a_timeout_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.timed_out |-> !result.busy_res && !result.byte_valid)
    else $error("timeout result while still busy or presenting a byte");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.byte_valid && result.last_byte |->
      !result.busy_res && result.byte_index == LAST_BYTE)
    else $error("last byte did not close the frame");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.byte_valid |-> result.byte_index <= LAST_BYTE)
    else $error("byte index beyond frame");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall && item_valid |=> $stable(phase) && result_valid)
    else $error("state advanced while result register was full");

endmodule
`default_nettype wire

/* tb/sv/dht11_single_wire_receiver_tb.sv */
`timescale 1ns / 1ps

module dht11_single_wire_receiver_tb;
  import dht11_pkg::*;

  // Run limit in clock cycles. The whole run is about a thousand transactions.
  // Even at 83% stall or idle, and with the register accesses and the long
  // hold-off added, a correct run stays well inside it: a wide margin.
  localparam int unsigned CYCLE_LIMIT = 200_000;

  // Index 3 is past the end of the register map, so a write to it must be ignored.
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam item_t IDLE_LO  = '{start_req: 1'b0, pin_level: 1'b0};
  localparam item_t IDLE_HI  = '{start_req: 1'b0, pin_level: 1'b1};
  localparam item_t START_LO = '{start_req: 1'b1, pin_level: 1'b0};
  localparam item_t START_HI = '{start_req: 1'b1, pin_level: 1'b1};

  localparam result_t RES_QUIET   = '0;
  localparam result_t RES_REQUEST = '{drive_low: 1'b1, busy_res: 1'b1, default: '0};
  localparam result_t RES_TIMEOUT = '{timed_out: 1'b1, default: '0};

  // One row of the opening sequence. If 'typed' is set, the expected result is
  // given in the row. Otherwise the decoder model below supplies it.
  typedef struct packed {
    logic    typed;
    item_t   stim;
    result_t want;
  } opening_row_t;

  // Config for these rows: request 2 ticks, sample delay 2, timeout 3.
  localparam int unsigned OPENING_LEN = 22;
  localparam opening_row_t OPENING_ROWS [OPENING_LEN] = '{
    '{1'b1, IDLE_LO,  RES_QUIET},    // idle, wire low: nothing happens
    '{1'b1, IDLE_HI,  RES_QUIET},    // idle, wire high: nothing happens
    '{1'b1, START_HI, RES_REQUEST},  // start: drive low from this tick
    '{1'b1, IDLE_LO,  RES_REQUEST},  // second tick of the request
    '{1'b0, IDLE_HI,  RES_QUIET},    // request over, now waiting for response
    '{1'b0, IDLE_HI,  RES_QUIET},
    '{1'b0, IDLE_HI,  RES_QUIET},
    '{1'b0, IDLE_HI,  RES_QUIET},
    '{1'b1, IDLE_HI,  RES_TIMEOUT},  // high with count at limit: give up
    '{1'b1, START_LO, RES_REQUEST},  // new request from idle
    '{1'b1, START_HI, RES_REQUEST},  // restart while still requesting
    '{1'b1, IDLE_HI,  RES_REQUEST},
    '{1'b0, IDLE_HI,  RES_QUIET},    // into response wait
    '{1'b0, IDLE_LO,  RES_QUIET},    // sensor pulls low
    '{1'b0, IDLE_HI,  RES_QUIET},    // sensor response high
    '{1'b0, IDLE_LO,  RES_QUIET},    // ready for first bit
    '{1'b0, IDLE_HI,  RES_QUIET},    // rising edge
    '{1'b0, IDLE_HI,  RES_QUIET},
    '{1'b0, IDLE_HI,  RES_QUIET},    // sampled high: a one
    '{1'b0, IDLE_LO,  RES_QUIET},    // falls, wait for next rise
    '{1'b0, IDLE_HI,  RES_QUIET},    // rising edge of second bit
    '{1'b1, START_LO, RES_REQUEST}   // start aborts the frame mid-bit
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  always #2 clk = ~clk;

  dht11_single_wire_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Decoder model state and the configuration it is working with.
  phase_t             dec_phase = PH_IDLE;
  logic [TICK_W-1:0]  dec_ticks = '0;
  logic [7:0]         dec_shift = '0;
  logic [CNT_W-1:0]   dec_bits = '0;
  logic [CNT_W-1:0]   dec_bytes = '0;
  logic [TICK_W-1:0]  cfg_request_low = REQUEST_LOW_RESET;
  logic [DELAY_W-1:0] cfg_sample_delay = SAMPLE_DELAY_RESET;
  logic [TICK_W-1:0]  cfg_resp_timeout = RESPONSE_TIMEOUT_RESET;

  result_t pending_results [$];   // one entry per accepted transaction, oldest first
  result_t oldest_pending;

  int unsigned idle_pct = 0;      // sender idle chance per cycle, percent
  int unsigned stall_pct = 0;     // receiver stall chance per cycle, percent
  int unsigned hold_off_left = 0; // long receiver hold-off, counted down by the checker
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_seen = 0;
  int unsigned frames_seen = 0;
  int unsigned timeouts_seen = 0;
  int unsigned settings_used = 0;
  int unsigned fail_count = 0;

  function automatic logic [TICK_W-1:0] bump(input logic [TICK_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advance the decoder model by one tick and return what the block should
  // present for that tick.
  function automatic result_t decode_tick(input item_t stim);
    result_t r;
    r = '0;
    if (stim.start_req) begin
      // start wins in every phase and does not look at the wire
      dec_phase = PH_REQUEST;
      dec_ticks = '0;
      dec_shift = '0;
      dec_bits  = '0;
      dec_bytes = '0;
    end else begin
      case (dec_phase)
        PH_REQUEST: begin
          dec_ticks = bump(dec_ticks);
          if (dec_ticks >= cfg_request_low) begin
            dec_phase = PH_WAIT_RESP;
            dec_ticks = '0;
          end
        end
        PH_WAIT_RESP: begin
          if (!stim.pin_level) begin
            dec_phase = PH_RESP_LOW;
            dec_ticks = '0;
          end else if (dec_ticks >= cfg_resp_timeout) begin
            r.timed_out = 1'b1;
            dec_phase = PH_IDLE;
            dec_ticks = '0;
          end else begin
            dec_ticks = bump(dec_ticks);
          end
        end
        PH_RESP_LOW:  if (stim.pin_level) dec_phase = PH_RESP_HIGH;
        PH_RESP_HIGH: if (!stim.pin_level) dec_phase = PH_WAIT_RISE;
        PH_WAIT_RISE: begin
          if (stim.pin_level) begin
            dec_phase = PH_SAMPLE;
            dec_ticks = '0;
          end
        end
        PH_SAMPLE: begin
          dec_ticks = bump(dec_ticks);
          if (dec_ticks >= TICK_W'(cfg_sample_delay)) begin
            dec_ticks = '0;
            dec_shift = {dec_shift[6:0], stim.pin_level};
            dec_phase = stim.pin_level ? PH_WAIT_FALL : PH_WAIT_RISE;
            if (dec_bits >= LAST_BIT) begin
              r.byte_valid = 1'b1;
              r.byte_value = dec_shift;
              r.byte_index = dec_bytes;
              r.last_byte  = (dec_bytes >= LAST_BYTE);
              dec_shift = '0;
              dec_bits  = '0;
              dec_bytes = dec_bytes + 1'b1;
              if (r.last_byte) begin
                // frame done: straight back to idle on this tick
                dec_phase = PH_IDLE;
                dec_bytes = '0;
              end
            end else begin
              dec_bits = dec_bits + 1'b1;
            end
          end
        end
        PH_WAIT_FALL: if (!stim.pin_level) dec_phase = PH_WAIT_RISE;
        default: dec_phase = PH_IDLE;
      endcase
    end
    r.drive_low = (dec_phase == PH_REQUEST);
    r.busy_res  = (dec_phase != PH_IDLE);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result side. It checks every transaction taken and drives the stall.
  // While hold_off_left is nonzero the stall stays high; otherwise it is
  // random at stall_pct.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected: %h", result);
          fail_count++;
        end else begin
          oldest_pending = pending_results.pop_front();
          check_field("drive_low",  oldest_pending.drive_low,  result.drive_low);
          check_field("byte_valid", oldest_pending.byte_valid, result.byte_valid);
          check_field("byte_value", oldest_pending.byte_value, result.byte_value);
          check_field("byte_index", oldest_pending.byte_index, result.byte_index);
          check_field("last_byte",  oldest_pending.last_byte,  result.last_byte);
          check_field("timed_out",  oldest_pending.timed_out,  result.timed_out);
          check_field("busy_res",   oldest_pending.busy_res,   result.busy_res);
          results_checked++;
          if (oldest_pending.byte_valid) bytes_seen++;
          if (oldest_pending.last_byte) frames_seen++;
          if (oldest_pending.timed_out) timeouts_seen++;
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left = hold_off_left - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Every task below is entered just after a rising edge and leaves just
  // after one. All drives are nonblocking.

  // Offer one input transaction and wait until it is taken. The expected
  // result is queued at the edge that takes it.
  task automatic offer(input item_t stim, input logic typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= stim;
    do @(posedge clk); while (item_stall);
    predicted = decode_tick(stim);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic tick(input logic start, input logic pin);
    offer('{start_req: start, pin_level: pin}, 1'b0, RES_QUIET);
  endtask

  // Drop valid, wait for every expected result, then idle before returning.
  // The block gives exactly one result per transaction, registered in the cycle after it is taken.
  task automatic wait_quiet();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_REQUEST_LOW:      cfg_request_low  = value[TICK_W-1:0];
      REG_SAMPLE_DELAY:     cfg_sample_delay = value[DELAY_W-1:0];
      REG_RESPONSE_TIMEOUT: cfg_resp_timeout = value[TICK_W-1:0];
      default: ;  // not mapped, write is ignored
    endcase
    @(posedge clk);
  endtask

  task automatic reg_check(input logic [1:0] idx, input logic [DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("register %0d readback: expected %0d, got %0d", idx, want, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_regs();
    reg_check(REG_REQUEST_LOW,      DATA_W'(cfg_request_low));
    reg_check(REG_SAMPLE_DELAY,     DATA_W'(cfg_sample_delay));
    reg_check(REG_RESPONSE_TIMEOUT, DATA_W'(cfg_resp_timeout));
  endtask

  // start, request ticks (wire ignored), then held high until the response times out
  task automatic run_timeout();
    tick(1'b1, 1'($urandom_range(1)));
    repeat ((cfg_request_low == 0) ? 1 : int'(cfg_request_low)) tick(1'b0, 1'($urandom_range(1)));
    repeat (int'(cfg_resp_timeout) + 1) tick(1'b0, 1'b1);
  endtask

  // Change the configuration only with the block idle and nothing in flight.
  // Each time, also write junk to the unmapped slot.
  task automatic set_config(input logic [TICK_W-1:0] req, input logic [DELAY_W-1:0] dly,
                            input logic [TICK_W-1:0] tmo);
    if (dec_phase != PH_IDLE) run_timeout();
    wait_quiet();
    // upper bits carry junk; only the register's own width is kept
    reg_write(REG_REQUEST_LOW,      ($urandom & 32'hFFFF_0000) | DATA_W'(req));
    reg_write(REG_SAMPLE_DELAY,     ($urandom & 32'hFFFF_FF00) | DATA_W'(dly));
    reg_write(REG_RESPONSE_TIMEOUT, ($urandom & 32'hFFFF_0000) | DATA_W'(tmo));
    reg_write(REG_SPARE, $urandom);
    verify_regs();
    settings_used++;
  endtask

  // Well-formed sensor exchange with random data, cut off at a random bit when broken.
  task automatic run_frame(input logic broken);
    int unsigned delay_n, high_n, cut;
    logic [7:0]  data;
    logic        b;
    data = '0;
    tick(1'b1, 1'($urandom_range(1)));
    repeat ((cfg_request_low == 0) ? 1 : int'(cfg_request_low)) tick(1'b0, 1'($urandom_range(1)));
    // a few high ticks before the response, never enough to time out
    high_n = $urandom_range(0, (cfg_resp_timeout < 3) ? int'(cfg_resp_timeout) : 3);
    repeat (high_n) tick(1'b0, 1'b1);
    repeat ($urandom_range(1, 3)) tick(1'b0, 1'b0);
    repeat ($urandom_range(1, 3)) tick(1'b0, 1'b1);
    repeat ($urandom_range(1, 3)) tick(1'b0, 1'b0);
    delay_n = (cfg_sample_delay == 0) ? 1 : int'(cfg_sample_delay);
    cut = broken ? $urandom_range(0, 39) : BYTES_PER_FRAME * BITS_PER_BYTE;
    for (int i = 0; i < cut; i++) begin
      if (i % 8 == 0) begin
        case ($urandom_range(3))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom);
        endcase
      end
      b = data[7 - (i % 8)];
      if (b) begin
        // still high at the sample point, then falls
        repeat (1 + delay_n + $urandom_range(0, 2)) tick(1'b0, 1'b1);
        repeat ($urandom_range(1, 2)) tick(1'b0, 1'b0);
      end else begin
        // short high, low by the sample point
        high_n = $urandom_range(0, delay_n - 1);
        repeat (1 + high_n) tick(1'b0, 1'b1);
        repeat (delay_n - high_n + $urandom_range(0, 1)) tick(1'b0, 1'b0);
      end
    end
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned stop_at, pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        run_frame(1'b0);
      end else if (pick < 70) begin
        run_frame(1'b1);
      end else if (pick < 82) begin
        run_timeout();
      end else begin
        // noise: random wire, occasional start
        repeat ($urandom_range(1, 8)) tick($urandom_range(99) < 15, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // registers should read back their reset values
    verify_regs();

    // Phase 1: no idling. Run the opening rows first. Then the receiver
    // holds off for a long stretch while the sender keeps offering, so the
    // block fills and stalls its input.
    set_config(16'd2, 8'd2, 16'd3);
    foreach (OPENING_ROWS[i])
      offer(OPENING_ROWS[i].stim, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
    hold_off_left = 300;
    random_traffic(110);

    // Phase 2: sender mostly idle, all registers at one.
    idle_pct = 83;
    set_config(16'd1, 8'd1, 16'd1);
    random_traffic(90);

    // Phase 3: receiver mostly stalled, all registers zero. A zero request
    // or delay acts as one tick; a zero timeout gives up on the first high.
    idle_pct  = 0;
    stall_pct = 83;
    set_config(16'd0, 8'd0, 16'd0);
    random_traffic(90);

    // Phase 4: light idling on both sides, random small settings.
    idle_pct  = 20;
    stall_pct = 20;
    set_config(16'($urandom_range(1, 6)), 8'($urandom_range(1, 6)), 16'($urandom_range(1, 8)));
    random_traffic(80);

    // Phase 5: all registers at their maximum, read back. The request is
    // far too long to finish here, so only its first ticks and a restart
    // in the middle of it are checked.
    idle_pct  = 0;
    stall_pct = 0;
    set_config(16'hFFFF, 8'hFF, 16'hFFFF);
    offer(START_HI, 1'b1, RES_REQUEST);
    repeat (8) offer(IDLE_HI, 1'b1, RES_REQUEST);
    offer(START_LO, 1'b1, RES_REQUEST);
    repeat (4) offer(IDLE_LO, 1'b1, RES_REQUEST);

    wait_quiet();
    repeat (10) @(posedge clk);
    $display("covered %0d transactions over %0d register settings, %0d results checked",
             items_sent, settings_used, results_checked);
    $display("decoded %0d bytes in %0d complete frames, %0d response timeouts",
             bytes_seen, frames_seen, timeouts_seen);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dht11_pkg.sv
rtl/dht11_single_wire_receiver.sv
tb/sv/dht11_single_wire_receiver_tb.sv
